// ===== design/pnt_pkg.sv =====
`default_nettype none
package pnt_pkg;

    // Field widths
    localparam int ADC_W   = 16;
    localparam int PED_W   = 24;
    localparam int NOISE_W = 24;
    localparam int CFG_W   = 16;

    // Default geometry
    localparam int SENSORS_DEF = 8;
    localparam int PIXELS_DEF  = 4096;

    // Fixed point fraction bits of pedestal and noise
    localparam int FRAC_BITS = 8;

    // Datapath widths
    localparam int AQ_W  = ADC_W + FRAC_BITS;
    localparam int PV_W  = ((AQ_W > PED_W) ? AQ_W : PED_W) + 1;
    localparam int MW    = PV_W + 1;
    localparam int SQ_W  = 2 * PV_W;
    localparam int DV_W  = SQ_W;
    localparam int CNT_W = $clog2(DV_W + 1);

    // Register indexes
    localparam logic CFG_WEIGHT = 1'b0;
    localparam logic CFG_PERIOD = 1'b1;

    // Item functions
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // Register reset values
    localparam logic [CFG_W-1:0] WEIGHT_RST = 16'd100;
    localparam logic [CFG_W-1:0] PERIOD_RST = 16'd10;

endpackage
`default_nettype wire

// ===== design/pnt_ram.sv =====
`default_nettype none
module pnt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32768
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read on one port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

// ===== design/pixel_pedestal_noise_tracker_unit.sv =====
`default_nettype none
// Channel  | handshake            | words
// ---------+----------------------+-------------------------------------------
// input    | in_valid / in_stall  | func sensor pixel adc pixel_good
//          |                      | load_pedestal load_noise event_last
// output   | out_valid / out_stall| pedestal_out noise_out updated
// config   | cfg_we               | cfg_index cfg_data
//
// One word at a time. Load words write the memory; samples without update
// read it and return the stored values; out of range words skip it. An
// updating sample runs the shared restoring divider twice and then the
// digit-by-digit square root, all iterating one bit per cycle.
// Reset clears the control state and the event phase; pixel memory is not
// cleared. A finished word waits in the output register; the next input
// word is taken as soon as the result has been moved there.
module pixel_pedestal_noise_tracker_unit #(
    parameter int SENSORS           = pnt_pkg::SENSORS_DEF,
    parameter int PIXELS_PER_SENSOR = pnt_pkg::PIXELS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              func,
    input  wire logic [2:0]                        sensor,
    input  wire logic [11:0]                       pixel,
    input  wire logic signed [pnt_pkg::ADC_W-1:0]  adc,
    input  wire logic                              pixel_good,
    input  wire logic signed [pnt_pkg::PED_W-1:0]  load_pedestal,
    input  wire logic [pnt_pkg::NOISE_W-1:0]       load_noise,
    input  wire logic                              event_last,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [pnt_pkg::PED_W-1:0]       pedestal_out,
    output logic [pnt_pkg::NOISE_W-1:0]            noise_out,
    output logic                                   updated,
    input  wire logic                              cfg_we,
    input  wire logic                              cfg_index,
    input  wire logic [pnt_pkg::CFG_W-1:0]         cfg_data
);

    localparam int DEPTH  = SENSORS * PIXELS_PER_SENSOR;
    localparam int AW     = $clog2(DEPTH);
    localparam int PV_W   = pnt_pkg::PV_W;
    localparam int MW     = pnt_pkg::MW;
    localparam int SQ_W   = pnt_pkg::SQ_W;
    localparam int DV_W   = pnt_pkg::DV_W;
    localparam int CNT_W  = pnt_pkg::CNT_W;
    localparam int PED_W  = pnt_pkg::PED_W;
    localparam int NS_W   = pnt_pkg::NOISE_W;
    localparam int CFG_W  = pnt_pkg::CFG_W;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_READ, S_DECIDE, S_MP, S_NUM, S_DIVP, S_PEDQ,
        S_MB, S_MN, S_NQ, S_DIVN, S_QF, S_SQRT, S_WB, S_DONE
    } state_t;

    state_t state_reg;

    // Configuration and event phase
    logic [CFG_W-1:0] weight_reg;
    logic [CFG_W-1:0] period_reg;
    logic [CFG_W-1:0] phase_reg;

    // Captured word
    logic                     func_reg;
    logic                     good_reg;
    logic                     last_reg;
    logic                     inr_reg;
    logic [AW-1:0]            addr_reg;
    logic signed [pnt_pkg::ADC_W-1:0] adc_reg;
    logic [PED_W-1:0]         lped_reg;
    logic [NS_W-1:0]          lnoise_reg;

    // Working values
    logic signed [PED_W-1:0]  ped_reg;
    logic [NS_W-1:0]          noise_reg;
    logic signed [2*MW-1:0]   prod_reg;
    logic [SQ_W-1:0]          b_reg;
    logic                     neg_reg;
    logic                     ge_reg;
    logic [DV_W-1:0]          dv_reg;
    logic [CFG_W-1:0]         rm_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [PV_W-1:0]          root_reg;
    logic [PV_W:0]            srem_reg;

    // Result staging and output
    logic [PED_W-1:0]         res_ped_reg;
    logic [NS_W-1:0]          res_noise_reg;
    logic                     res_upd_reg;
    logic                     out_valid_reg;
    logic [PED_W-1:0]         out_ped_reg;
    logic [NS_W-1:0]          out_noise_reg;
    logic                     out_upd_reg;

    // Memory port
    logic                     ram_we;
    logic [PED_W+NS_W-1:0]    ram_wdata;
    logic [PED_W+NS_W-1:0]    ram_rdata;

    // Derived operands
    logic [CFG_W-1:0]         wv;
    logic [CFG_W-1:0]         pv;
    logic [31:0]              addr_full;
    logic                     in_range;
    logic                     accept;
    logic signed [PV_W-1:0]   adc_q;
    logic signed [MW-1:0]     diff;
    logic [PV_W-1:0]          ad;
    logic signed [MW-1:0]     mul_a;
    logic signed [MW-1:0]     mul_b;
    logic signed [2*MW-1:0]   mul_p;
    logic signed [2*MW-1:0]   num;
    logic [2*MW-1:0]          num_mag;
    logic signed [DV_W:0]     qs;
    logic [SQ_W-1:0]          n2;
    logic [SQ_W-1:0]          qf;
    logic [NS_W-1:0]          nn;
    logic [CFG_W:0]           dt;
    logic                     dge;
    logic [CFG_W:0]           drem;
    logic [PV_W+2:0]          sr;
    logic [PV_W+2:0]          st;
    logic                     sge;
    logic [PV_W+2:0]          sdiff;
    logic [CFG_W:0]           phase_inc;

    assign wv = (weight_reg == '0) ? CFG_W'(1) : weight_reg;
    assign pv = (period_reg == '0) ? CFG_W'(1) : period_reg;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    // Locate the pixel in memory
    assign addr_full = 32'(sensor) * 32'(PIXELS_PER_SENSOR) + 32'(pixel);
    assign in_range  = (32'(sensor) < 32'(SENSORS)) && (32'(pixel) < 32'(PIXELS_PER_SENSOR));

    // Scale the sample to pedestal format
    assign adc_q = $signed({{(PV_W-pnt_pkg::ADC_W){adc_reg[pnt_pkg::ADC_W-1]}}, adc_reg})
                   <<< pnt_pkg::FRAC_BITS;

    // Residual of the sample against the new pedestal
    always_comb
    begin
        diff = $signed({adc_q[PV_W-1], adc_q})
             - $signed({{(MW-PED_W){ped_reg[PED_W-1]}}, ped_reg});
        ad   = diff[MW-1] ? PV_W'(-diff) : PV_W'(diff);
    end

    // Shared multiplier, operands picked by the sequencer
    always_comb
    begin
        case (state_reg)
            S_MP:
            begin
                mul_a = $signed(MW'(wv - CFG_W'(1)));
                mul_b = $signed({{(MW-PED_W){ped_reg[PED_W-1]}}, ped_reg});
            end
            S_MB:
            begin
                mul_a = $signed({1'b0, ad});
                mul_b = $signed({1'b0, ad});
            end
            S_MN:
            begin
                mul_a = $signed(MW'(noise_reg));
                mul_b = $signed(MW'(noise_reg));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Pedestal numerator and its magnitude
    always_comb
    begin
        num     = prod_reg + (2*MW)'(adc_q);
        num_mag = num[2*MW-1] ? (2*MW)'(-num) : (2*MW)'(num);
    end

    // Signed quotient of the pedestal division
    assign qs = neg_reg ? -$signed({1'b0, dv_reg}) : $signed({1'b0, dv_reg});

    // Noise quotient with floor division toward minus infinity
    always_comb
    begin
        n2 = prod_reg[SQ_W-1:0];
        if (ge_reg)
        begin
            qf = n2 + dv_reg;
        end
        else
        begin
            qf = n2 - (dv_reg + SQ_W'(rm_reg != '0));
        end
    end

    // Saturate the root to the noise width
    assign nn = (|root_reg[PV_W-1:NS_W]) ? {NS_W{1'b1}} : root_reg[NS_W-1:0];

    // Restoring divider step
    always_comb
    begin
        dt   = {rm_reg, dv_reg[DV_W-1]};
        dge  = dt >= {1'b0, wv};
        drem = dge ? (dt - {1'b0, wv}) : dt;
    end

    // Square root step
    always_comb
    begin
        sr    = {srem_reg, sq_reg[SQ_W-1 -: 2]};
        st    = {1'b0, root_reg, 2'b01};
        sge   = sr >= st;
        sdiff = sge ? (sr - st) : sr;
    end

    assign phase_inc = {1'b0, phase_reg} + (CFG_W+1)'(1);

    // Memory write for loads and updates
    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = {lped_reg, lnoise_reg};
        case (state_reg)
            S_LOAD:
            begin
                ram_we = 1'b1;
            end
            S_WB:
            begin
                ram_we    = 1'b1;
                ram_wdata = {ped_reg, nn};
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    pnt_ram #(
        .WIDTH (PED_W + NS_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (addr_reg),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Sequencer, datapath registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            weight_reg    <= pnt_pkg::WEIGHT_RST;
            period_reg    <= pnt_pkg::PERIOD_RST;
            phase_reg     <= '0;
            func_reg      <= 1'b0;
            good_reg      <= 1'b0;
            last_reg      <= 1'b0;
            inr_reg       <= 1'b0;
            addr_reg      <= '0;
            adc_reg       <= '0;
            lped_reg      <= '0;
            lnoise_reg    <= '0;
            ped_reg       <= '0;
            noise_reg     <= '0;
            prod_reg      <= '0;
            b_reg         <= '0;
            neg_reg       <= 1'b0;
            ge_reg        <= 1'b0;
            dv_reg        <= '0;
            rm_reg        <= '0;
            cnt_reg       <= '0;
            sq_reg        <= '0;
            root_reg      <= '0;
            srem_reg      <= '0;
            res_ped_reg   <= '0;
            res_noise_reg <= '0;
            res_upd_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_ped_reg   <= '0;
            out_noise_reg <= '0;
            out_upd_reg   <= 1'b0;
        end
        else
        begin
            // Take register writes
            if (cfg_we)
            begin
                if (cfg_index == pnt_pkg::CFG_WEIGHT)
                begin
                    weight_reg <= cfg_data;
                end
                else
                begin
                    period_reg <= cfg_data;
                end
            end

            // Drop the output word once taken, unless a new one replaces it
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            // Hold the multiplier result
            if (state_reg == S_MP || state_reg == S_MB || state_reg == S_MN)
            begin
                prod_reg <= mul_p;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        func_reg      <= func;
                        good_reg      <= pixel_good;
                        last_reg      <= event_last;
                        inr_reg       <= in_range;
                        addr_reg      <= addr_full[AW-1:0];
                        adc_reg       <= adc;
                        lped_reg      <= load_pedestal;
                        lnoise_reg    <= load_noise;
                        res_ped_reg   <= '0;
                        res_noise_reg <= '0;
                        res_upd_reg   <= 1'b0;
                        if (!in_range)
                        begin
                            state_reg <= S_DONE;
                        end
                        else if (func == pnt_pkg::FUNC_LOAD)
                        begin
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_LOAD:
                begin
                    res_ped_reg   <= lped_reg;
                    res_noise_reg <= lnoise_reg;
                    state_reg     <= S_DONE;
                end
                S_READ:
                begin
                    state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    ped_reg   <= ram_rdata[PED_W+NS_W-1:NS_W];
                    noise_reg <= ram_rdata[NS_W-1:0];
                    if (phase_reg == '0 && good_reg)
                    begin
                        state_reg <= S_MP;
                    end
                    else
                    begin
                        res_ped_reg   <= ram_rdata[PED_W+NS_W-1:NS_W];
                        res_noise_reg <= ram_rdata[NS_W-1:0];
                        state_reg     <= S_DONE;
                    end
                end
                S_MP:
                begin
                    state_reg <= S_NUM;
                end
                S_NUM:
                begin
                    // Start the pedestal division on the magnitude
                    neg_reg   <= num[2*MW-1];
                    dv_reg    <= num_mag[DV_W-1:0];
                    rm_reg    <= '0;
                    cnt_reg   <= CNT_W'(DV_W);
                    state_reg <= S_DIVP;
                end
                S_DIVP, S_DIVN:
                begin
                    dv_reg  <= {dv_reg[DV_W-2:0], dge};
                    rm_reg  <= drem[CFG_W-1:0];
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_reg <= (state_reg == S_DIVP) ? S_PEDQ : S_QF;
                    end
                end
                S_PEDQ:
                begin
                    // Saturate the new pedestal
                    if (qs > $signed((DV_W+1)'({1'b0, {(PED_W-1){1'b1}}})))
                    begin
                        ped_reg <= {1'b0, {(PED_W-1){1'b1}}};
                    end
                    else if (qs < -$signed((DV_W+1)'({1'b1, {(PED_W-1){1'b0}}})))
                    begin
                        ped_reg <= {1'b1, {(PED_W-1){1'b0}}};
                    end
                    else
                    begin
                        ped_reg <= qs[PED_W-1:0];
                    end
                    state_reg <= S_MB;
                end
                S_MB:
                begin
                    state_reg <= S_MN;
                end
                S_MN:
                begin
                    b_reg     <= prod_reg[SQ_W-1:0];
                    state_reg <= S_NQ;
                end
                S_NQ:
                begin
                    // Start the noise division on the distance from n^2
                    ge_reg    <= b_reg >= n2;
                    dv_reg    <= (b_reg >= n2) ? (b_reg - n2) : (n2 - b_reg);
                    rm_reg    <= '0;
                    cnt_reg   <= CNT_W'(DV_W);
                    state_reg <= S_DIVN;
                end
                S_QF:
                begin
                    sq_reg    <= qf;
                    root_reg  <= '0;
                    srem_reg  <= '0;
                    cnt_reg   <= CNT_W'(PV_W);
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    sq_reg   <= {sq_reg[SQ_W-3:0], 2'b00};
                    root_reg <= {root_reg[PV_W-2:0], sge};
                    srem_reg <= sdiff[PV_W:0];
                    cnt_reg  <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_reg <= S_WB;
                    end
                end
                S_WB:
                begin
                    res_ped_reg   <= ped_reg;
                    res_noise_reg <= nn;
                    res_upd_reg   <= 1'b1;
                    state_reg     <= S_DONE;
                end
                S_DONE:
                begin
                    // Move the result out and, after the last sample of an event, advance the event phase
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        out_ped_reg   <= res_ped_reg;
                        out_noise_reg <= res_noise_reg;
                        out_upd_reg   <= res_upd_reg;
                        if (func_reg == pnt_pkg::FUNC_SAMPLE && last_reg)
                        begin
                            phase_reg <= (phase_inc >= {1'b0, pv}) ? '0
                                                                   : phase_inc[CFG_W-1:0];
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign pedestal_out = out_ped_reg;
    assign noise_out    = out_noise_reg;
    assign updated      = out_upd_reg;

    // An accepted word makes the block busy at once
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("block not busy after accepting a word");

    // The event phase moves only when a result is released
    a_phase_at_done: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != $past(phase_reg)) |-> ($past(state_reg) == S_DONE))
        else $error("event phase changed outside result release");

    // Iterating states always have steps left
    a_iter_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVP || state_reg == S_DIVN || state_reg == S_SQRT)
        |-> (cnt_reg != '0))
        else $error("iteration counter empty while iterating");

    // An updated result comes only from a sample word
    a_update_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WB) |-> (func_reg == pnt_pkg::FUNC_SAMPLE && inr_reg))
        else $error("update write for a load or out of range word");

endmodule
`default_nettype wire

// ===== tb/tb_pixel_pedestal_noise_tracker_unit.sv =====
module tb_pixel_pedestal_noise_tracker_unit;

    localparam int ADC_W   = pnt_pkg::ADC_W;
    localparam int PED_W   = pnt_pkg::PED_W;
    localparam int NOISE_W = pnt_pkg::NOISE_W;
    localparam int CFG_W   = pnt_pkg::CFG_W;

    localparam int STALL_LIMIT = 6000;
    localparam int DRAIN_CYCLES = 200;
    localparam int NUM_ADDR = 8 * 4096;

    typedef struct {
        logic                      func;
        logic [2:0]                sensor;
        logic [11:0]               pixel;
        logic signed [ADC_W-1:0]   adc;
        logic                      pixel_good;
        logic signed [PED_W-1:0]   load_pedestal;
        logic [NOISE_W-1:0]        load_noise;
        logic                      event_last;
    } pix_word_t;

    typedef struct {
        logic [PED_W-1:0]   ped;
        logic [NOISE_W-1:0] noise;
        logic               upd;
    } pix_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic func = 1'b0;
    logic [2:0] sensor = '0;
    logic [11:0] pixel = '0;
    logic signed [ADC_W-1:0] adc = '0;
    logic pixel_good = 1'b0;
    logic signed [PED_W-1:0] load_pedestal = '0;
    logic [NOISE_W-1:0] load_noise = '0;
    logic event_last = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [PED_W-1:0] pedestal_out;
    logic [NOISE_W-1:0] noise_out;
    logic updated;
    logic cfg_we = 1'b0;
    logic cfg_index = pnt_pkg::CFG_WEIGHT;
    logic [CFG_W-1:0] cfg_data = '0;

    pixel_pedestal_noise_tracker_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .sensor(sensor), .pixel(pixel), .adc(adc),
        .pixel_good(pixel_good), .load_pedestal(load_pedestal),
        .load_noise(load_noise), .event_last(event_last),
        .out_valid(out_valid), .out_stall(out_stall),
        .pedestal_out(pedestal_out), .noise_out(noise_out), .updated(updated),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Tracker copy kept by the bench
    logic signed [PED_W-1:0] ped_mem [NUM_ADDR];
    logic [NOISE_W-1:0]      noise_mem [NUM_ADDR];
    logic [15:0]             phase_cnt = '0;
    logic [CFG_W-1:0]        weight_reg = pnt_pkg::WEIGHT_RST;
    logic [CFG_W-1:0]        period_reg = pnt_pkg::PERIOD_RST;

    pix_word_t   word_queue[$];
    pix_result_t result_expect_q[$];
    bit          loaded_map [NUM_ADDR];
    int          addr_pool [32];
    int          send_gap = 0;
    int          recv_hold = 0;
    bit          hold_sender = 1'b0;
    bit          long_hold_req = 1'b0;
    int          mismatch_cnt = 0;
    int          idle_cycles = 0;
    bit          moved;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned trial;
        res = 0;
        for (int i = 31; i >= 0; i--)
        begin
            trial = res | (64'd1 << i);
            if (trial * trial <= v)
                res = trial;
        end
        return res;
    endfunction

    // Advance the tracker copy by one word and return what the block must emit
    function automatic pix_result_t track_pixel(input pix_word_t w);
        pix_result_t r;
        int a;
        longint ped, np, adc_q, d, wt;
        longint unsigned noise, n2, b, q, nn, ad, uw;
        logic [15:0] per;
        a = {w.sensor, w.pixel};
        r.upd = 1'b0;
        if (w.func == pnt_pkg::FUNC_LOAD)
        begin
            ped_mem[a] = w.load_pedestal;
            noise_mem[a] = w.load_noise;
            r.ped = w.load_pedestal;
            r.noise = w.load_noise;
            return r;
        end
        ped = longint'(ped_mem[a]);
        noise = longint'(noise_mem[a]);
        wt = (weight_reg == 0) ? 1 : longint'(weight_reg);
        if (phase_cnt == 0 && w.pixel_good)
        begin
            adc_q = longint'(w.adc) * 256;
            np = ((wt - 1) * ped + adc_q) / wt;
            if (np > 64'sd8388607) np = 64'sd8388607;
            if (np < -64'sd8388608) np = -64'sd8388608;
            d = adc_q - np;
            ad = (d < 0) ? -d : d;
            b = ad * ad;
            n2 = noise * noise;
            uw = wt;
            if (b >= n2)
                q = n2 + (b - n2) / uw;
            else
                q = n2 - (n2 - b + uw - 1) / uw;
            nn = floor_sqrt(q);
            if (nn > 64'hFFFFFF) nn = 64'hFFFFFF;
            ped_mem[a] = np[PED_W-1:0];
            noise_mem[a] = nn[NOISE_W-1:0];
            ped = np;
            noise = nn;
            r.upd = 1'b1;
        end
        r.ped = ped[PED_W-1:0];
        r.noise = noise[NOISE_W-1:0];
        // wrap the event phase at the period
        if (w.event_last)
        begin
            per = (period_reg == 0) ? 16'd1 : period_reg;
            phase_cnt = (32'(phase_cnt) + 1 >= 32'(per)) ? 16'd0 : phase_cnt + 16'd1;
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // Driver: predict on acceptance, then offer the next word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                result_expect_q = {result_expect_q,
                    track_pixel('{func, sensor, pixel, adc, pixel_good,
                                  load_pedestal, load_noise, event_last})};
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (hold_sender || word_queue.size() == 0)
                    in_valid <= 1'b0;
                else
                begin
                    pix_word_t w;
                    w = word_queue.pop_front();
                    func <= w.func;
                    sensor <= w.sensor;
                    pixel <= w.pixel;
                    adc <= w.adc;
                    pixel_good <= w.pixel_good;
                    load_pedestal <= w.load_pedestal;
                    load_noise <= w.load_noise;
                    event_last <= w.event_last;
                    in_valid <= 1'b1;
                    send_gap = pick_gap();
                end
            end
        end
    end

    // Monitor: compare results, randomize stall, watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            moved = (in_valid && !in_stall) || (out_valid && !out_stall);
            if (out_valid && !out_stall)
            begin
                if (result_expect_q.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected word: ped %h noise %h upd %b",
                                 pedestal_out, noise_out, updated);
                end
                else
                begin
                    pix_result_t e;
                    e = result_expect_q.pop_front();
                    if (pedestal_out !== e.ped || noise_out !== e.noise || updated !== e.upd)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display({"mismatch: ped exp %h got %h, noise exp %h got %h,",
                                      " upd exp %b got %b"},
                                     e.ped, pedestal_out, e.noise, noise_out, e.upd, updated);
                    end
                end
            end
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                recv_hold = 500;
            end
            else if (recv_hold == 0)
                recv_hold = pick_gap();
            if (recv_hold > 0)
            begin
                recv_hold--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic add_load(input int a, input logic [PED_W-1:0] p, input logic [NOISE_W-1:0] n);
        pix_word_t w;
        w = '{pnt_pkg::FUNC_LOAD, a[14:12], a[11:0], 16'($urandom), 1'($urandom), p, n,
              1'($urandom)};
        loaded_map[a] = 1'b1;
        word_queue = {word_queue, w};
    endtask

    task automatic add_sample(input int a, input logic [ADC_W-1:0] v, input logic g,
                              input logic last);
        pix_word_t w;
        w = '{pnt_pkg::FUNC_SAMPLE, a[14:12], a[11:0], v, g, 24'($urandom), 24'($urandom),
              last};
        word_queue = {word_queue, w};
    endtask

    // Wait for the block to drain completely
    task automatic settle();
        while (word_queue.size() != 0 || in_valid || result_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == pnt_pkg::CFG_WEIGHT)
            weight_reg = val;
        else
            period_reg = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_words(input int count);
        int a, r;
        logic [ADC_W-1:0] v;
        for (int i = 0; i < count; i++)
        begin
            a = addr_pool[$urandom_range(0, 31)];
            r = $urandom_range(0, 99);
            if (!loaded_map[a] || r < 15)
                add_load(a, 24'($urandom), ($urandom_range(0, 3) == 0) ? 24'($urandom)
                         : 24'($urandom_range(0, 4095)));
            else
            begin
                v = ($urandom_range(0, 2) == 0) ? 16'($urandom)
                    : 16'($signed($urandom_range(0, 400)) - 200);
                add_sample(a, v, $urandom_range(0, 5) != 0, $urandom_range(0, 5) == 0);
            end
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] wset [6];
        logic [CFG_W-1:0] pset [6];
        wset = '{16'd100, 16'd1, 16'd2, 16'd0, 16'd65535, 16'd7};
        pset = '{16'd10, 16'd1, 16'd3, 16'd0, 16'd65535, 16'd2};
        addr_pool[0] = 0;
        addr_pool[1] = NUM_ADDR - 1;
        for (int i = 2; i < 32; i++)
            addr_pool[i] = $urandom_range(0, NUM_ADDR - 1);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, both functions, bad pixels, event wrap
        add_load(0, 24'h7FFFFF, 24'hFFFFFF);
        add_load(NUM_ADDR - 1, 24'h800000, 24'h000000);
        add_load(12345, 24'h000000, 24'h000100);
        add_sample(0, 16'h7FFF, 1'b1, 1'b0);
        add_sample(NUM_ADDR - 1, 16'h8000, 1'b1, 1'b0);
        add_sample(12345, 16'h0000, 1'b0, 1'b0);
        add_sample(12345, 16'hFFFF, 1'b1, 1'b1);
        add_sample(0, 16'h8000, 1'b1, 1'b1);
        add_sample(NUM_ADDR - 1, 16'h7FFF, 1'b1, 1'b0);
        add_load(0, 24'h800000, 24'hFFFFFF);
        add_sample(0, 16'h8000, 1'b1, 1'b0);
        settle();
        write_reg(pnt_pkg::CFG_WEIGHT, 16'd1);
        write_reg(pnt_pkg::CFG_PERIOD, 16'd1);
        add_sample(0, 16'h7FFF, 1'b1, 1'b1);
        add_sample(NUM_ADDR - 1, 16'h1234, 1'b1, 1'b1);
        settle();

        // Random phases under several register settings
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(pnt_pkg::CFG_WEIGHT, wset[ph]);
            write_reg(pnt_pkg::CFG_PERIOD, pset[ph]);
            if (ph == 1)
            begin
                random_words(70);
                while (word_queue.size() != 0) @(posedge clk);
                hold_sender = 1'b1;
                while (in_valid || result_expect_q.size() != 0) @(posedge clk);
                hold_sender = 1'b0;
                random_words(80);
            end
            else
            begin
                if (ph == 2)
                    long_hold_req = 1'b1;
                random_words(150);
            end
            settle();
        end

        if (mismatch_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== pixel_pedestal_noise_tracker_unit.f =====
design/pnt_pkg.sv
design/pnt_ram.sv
design/pixel_pedestal_noise_tracker_unit.sv
tb/tb_pixel_pedestal_noise_tracker_unit.sv
